>>> hdl/sfa_pkg.sv
package sfa_pkg;

    // Size class codes, as carried on the result channel and in the tag store
    localparam logic [1:0] CLS_SMALL  = 2'd0;
    localparam logic [1:0] CLS_MEDIUM = 2'd1;
    localparam logic [1:0] CLS_LARGE  = 2'd2;

    // Request kinds on the input channel
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Write strobes from the sequencer to the link and tag stores
    typedef struct packed {
        logic link_we;
        logic tag_we;
    } store_ctl_t;

endpackage

>>> hdl/sfa_step.sv
// Shared add and compare unit: sum = a + b, lt = sum < c
module sfa_step #(
    parameter int W = 8
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic [W-1:0] c,
    output logic [W-1:0] sum,
    output logic         lt
);

    always_comb begin
        sum = a + b;
        lt  = (sum < c);
    end

endmodule

>>> hdl/sfa_store.sv
// Link store (next pointer plus valid bit) and class tag store, one
// write and one registered read each per cycle
module sfa_store import sfa_pkg::*; #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic          aclk,
    input  store_ctl_t    ctl,
    input  logic [AW-1:0] link_waddr,
    input  logic [AW-1:0] link_wlink,
    input  logic          link_wvalid,
    input  logic [AW-1:0] link_raddr,
    output logic [AW-1:0] link_rlink,
    output logic          link_rvalid,
    input  logic [AW-1:0] tag_waddr,
    input  logic [1:0]    tag_wdata,
    input  logic [AW-1:0] tag_raddr,
    output logic [1:0]    tag_rdata
);

    logic [AW:0]   link_mem [DEPTH];
    logic [1:0]    tag_mem  [DEPTH];
    logic [AW:0]   link_rd_reg;
    logic [1:0]    tag_rd_reg;

    // Write and read both stores
    always_ff @(posedge aclk) begin
        if (ctl.link_we) begin
            link_mem[link_waddr] <= {link_wvalid, link_wlink};
        end
        link_rd_reg <= link_mem[link_raddr];
        if (ctl.tag_we) begin
            tag_mem[tag_waddr] <= tag_wdata;
        end
        tag_rd_reg <= tag_mem[tag_raddr];
    end

    assign link_rvalid = link_rd_reg[AW];
    assign link_rlink  = link_rd_reg[AW-1:0];
    assign tag_rdata   = tag_rd_reg;

endmodule

>>> hdl/segregated_freelist_allocator_unit.sv
// Pool allocator with three LIFO free lists (small, medium, large cells),
// one item at a time. After reset the block chains the large cells, one per
// cycle (POOL_PAGES*PAGE_BYTES/LARGE_BYTES cells, 16 by default), before it
// first raises s_ready. An allocate climbs to the first class with a free
// cell and pops its head. From a class above the one wanted, the cell is
// carved down level by level, one cell per cycle by the shared add/compare
// unit. By default that is 8 small cells from a medium and 16 medium cells
// from a large. A free does a reciprocal multiply for the offset, a tag read
// and the push. s_ready returns in the cycle m_valid rises. While a result
// is stalled, the next item waits in its last step. Offsets are in bytes.
// Frees are aligned down to SMALL_BYTES, and a free past the pool returns
// granted 0 with the offset echoed.
module segregated_freelist_allocator_unit import sfa_pkg::*; #(
    parameter int SMALL_BYTES  = 32,
    parameter int MEDIUM_BYTES = 256,
    parameter int LARGE_BYTES  = 4096,
    parameter int PAGE_BYTES   = 4096,
    parameter int POOL_PAGES   = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [15:0] s_request_bytes,
    input  logic [15:0] s_cell_offset,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_granted,
    output logic [15:0] m_result_offset,
    output logic [1:0]  m_size_class
);

    localparam int UNITS  = (POOL_PAGES * PAGE_BYTES) / SMALL_BYTES;
    localparam int MU     = (MEDIUM_BYTES / SMALL_BYTES) > 0 ? MEDIUM_BYTES / SMALL_BYTES : 1;
    localparam int LU     = (LARGE_BYTES / SMALL_BYTES) > 0 ? LARGE_BYTES / SMALL_BYTES : 1;
    localparam int DEPTH  = UNITS > 0 ? UNITS : 1;
    localparam int UW     = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int SW     = $clog2(UNITS + LU + MU + 1);
    localparam int SL     = $clog2(SMALL_BYTES);
    localparam int DIV_SH = 16 + SL;
    localparam longint unsigned DIV_MUL =
        ((64'd1 << DIV_SH) + SMALL_BYTES - 1) / SMALL_BYTES;
    localparam int PW     = 33;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_FIND,
        ST_POP,
        ST_POP_WAIT,
        ST_CARVE,
        ST_DIV,
        ST_FREE_CHK,
        ST_FREE_WAIT,
        ST_DONE
    } state_t;

    state_t        state_reg, state_next;
    logic [1:0]    lvl_reg, lvl_next;
    logic [1:0]    req_cls_reg, req_cls_next;
    logic [15:0]   off_reg, off_next;
    logic [PW-1:0] prod_reg, prod_next;
    logic [UW-1:0] unit_reg, unit_next;
    logic [UW-1:0] cur_reg, cur_next;
    logic [SW-1:0] limit_reg, limit_next;
    logic [UW-1:0] head_reg [0:2];
    logic [UW-1:0] head_next [0:2];
    logic [2:0]    empty_reg, empty_next;
    logic          ok_reg, ok_next;
    logic          echo_reg, echo_next;
    logic [1:0]    res_cls_reg, res_cls_next;
    logic          m_valid_reg, m_valid_next;
    logic          m_granted_reg, m_granted_next;
    logic [15:0]   m_offset_reg, m_offset_next;
    logic [1:0]    m_class_reg, m_class_next;

    // Shared unit operands
    logic [SW-1:0] step_a, step_b, step_c, step_sum;
    logic          step_lt;

    // Store ports
    store_ctl_t    st_ctl;
    logic [UW-1:0] link_waddr, link_wlink, link_raddr, link_rlink;
    logic          link_wvalid, link_rvalid;
    logic [UW-1:0] tag_waddr, tag_raddr;
    logic [1:0]    tag_wdata, tag_rdata;

    logic [1:0]    tgt;
    logic [1:0]    tag_cls;
    logic [1:0]    in_cls;
    logic [15:0]   unit_wide;
    logic [UW+15:0] off_prod;

    sfa_step #(.W(SW)) u_step (
        .a   (step_a),
        .b   (step_b),
        .c   (step_c),
        .sum (step_sum),
        .lt  (step_lt)
    );

    sfa_store #(.DEPTH(DEPTH), .AW(UW)) u_store (
        .aclk        (aclk),
        .ctl         (st_ctl),
        .link_waddr  (link_waddr),
        .link_wlink  (link_wlink),
        .link_wvalid (link_wvalid),
        .link_raddr  (link_raddr),
        .link_rlink  (link_rlink),
        .link_rvalid (link_rvalid),
        .tag_waddr   (tag_waddr),
        .tag_wdata   (tag_wdata),
        .tag_raddr   (tag_raddr),
        .tag_rdata   (tag_rdata)
    );

    // Class wanted by the incoming request
    always_comb begin
        if ({16'd0, s_request_bytes} <= 32'(SMALL_BYTES)) begin
            in_cls = CLS_SMALL;
        end else if ({16'd0, s_request_bytes} <= 32'(MEDIUM_BYTES)) begin
            in_cls = CLS_MEDIUM;
        end else begin
            in_cls = CLS_LARGE;
        end
    end

    assign tgt       = lvl_reg - 2'd1;
    assign tag_cls   = (tag_rdata == CLS_SMALL || tag_rdata == CLS_MEDIUM) ? tag_rdata
                                                                           : CLS_LARGE;
    assign unit_wide = 16'(prod_reg >> DIV_SH);
    assign off_prod  = (UW+16)'(unit_reg) * (UW+16)'(SMALL_BYTES);

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        lvl_next       = lvl_reg;
        req_cls_next   = req_cls_reg;
        off_next       = off_reg;
        prod_next      = prod_reg;
        unit_next      = unit_reg;
        cur_next       = cur_reg;
        limit_next     = limit_reg;
        head_next      = head_reg;
        empty_next     = empty_reg;
        ok_next        = ok_reg;
        echo_next      = echo_reg;
        res_cls_next   = res_cls_reg;
        m_valid_next   = m_valid_reg;
        m_granted_next = m_granted_reg;
        m_offset_next  = m_offset_reg;
        m_class_next   = m_class_reg;

        step_a = SW'(cur_reg);
        step_b = SW'(LU);
        step_c = SW'(UNITS);

        st_ctl      = '0;
        link_waddr  = cur_reg;
        link_wlink  = '0;
        link_wvalid = 1'b0;
        link_raddr  = head_reg[lvl_reg];
        tag_waddr   = unit_reg;
        tag_wdata   = lvl_reg;
        tag_raddr   = UW'(unit_wide);

        // Drop the result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_INIT: begin
                // Chain the large cells in address order
                if (UNITS == 0) begin
                    state_next = ST_IDLE;
                end else begin
                    st_ctl.link_we = 1'b1;
                    link_wvalid    = step_lt;
                    link_wlink     = step_lt ? UW'(step_sum) : '0;
                    if (step_lt) begin
                        cur_next = UW'(step_sum);
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_kind == KIND_ALLOC) begin
                        req_cls_next = in_cls;
                        lvl_next     = in_cls;
                        state_next   = ST_FIND;
                    end else begin
                        off_next   = s_cell_offset;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_FIND: begin
                // Climb to the first class with a free cell
                if (!empty_reg[lvl_reg]) begin
                    state_next = ST_POP;
                end else if (lvl_reg == CLS_LARGE) begin
                    ok_next      = 1'b0;
                    echo_next    = 1'b0;
                    res_cls_next = req_cls_reg;
                    state_next   = ST_DONE;
                end else begin
                    lvl_next = lvl_reg + 2'd1;
                end
            end
            ST_POP: begin
                // Read the head's link
                unit_next  = head_reg[lvl_reg];
                state_next = ST_POP_WAIT;
            end
            ST_POP_WAIT: begin
                head_next[lvl_reg]  = link_rlink;
                empty_next[lvl_reg] = !link_rvalid;
                st_ctl.tag_we       = 1'b1;
                if (lvl_reg == req_cls_reg) begin
                    ok_next      = 1'b1;
                    echo_next    = 1'b0;
                    res_cls_next = req_cls_reg;
                    state_next   = ST_DONE;
                end else begin
                    // Clip the carve span at the pool's end
                    step_a     = SW'(unit_reg);
                    step_b     = (tgt == CLS_MEDIUM) ? SW'(LU) : SW'(MU);
                    step_c     = SW'(UNITS);
                    limit_next = step_lt ? step_sum : SW'(UNITS);
                    cur_next   = unit_reg;
                    state_next = ST_CARVE;
                end
            end
            ST_CARVE: begin
                // Link one cell per cycle, the last one ends on the old list
                step_a         = SW'(cur_reg);
                step_b         = (tgt == CLS_MEDIUM) ? SW'(MU) : SW'(1);
                step_c         = limit_reg;
                st_ctl.link_we = 1'b1;
                if (step_lt) begin
                    link_wlink  = UW'(step_sum);
                    link_wvalid = 1'b1;
                    cur_next    = UW'(step_sum);
                end else begin
                    link_wlink      = head_reg[tgt];
                    link_wvalid     = !empty_reg[tgt];
                    head_next[tgt]  = unit_reg;
                    empty_next[tgt] = 1'b0;
                    lvl_next        = tgt;
                    state_next      = ST_POP;
                end
            end
            ST_DIV: begin
                // Offset to unit by reciprocal multiply
                prod_next  = PW'(off_reg) * PW'(DIV_MUL);
                state_next = ST_FREE_CHK;
            end
            ST_FREE_CHK: begin
                if ({16'd0, unit_wide} >= 32'(UNITS)) begin
                    ok_next      = 1'b0;
                    echo_next    = 1'b1;
                    res_cls_next = CLS_SMALL;
                    state_next   = ST_DONE;
                end else begin
                    unit_next  = UW'(unit_wide);
                    state_next = ST_FREE_WAIT;
                end
            end
            ST_FREE_WAIT: begin
                // Push the cell onto its tagged list
                st_ctl.link_we      = 1'b1;
                link_waddr          = unit_reg;
                link_wlink          = head_reg[tag_cls];
                link_wvalid         = !empty_reg[tag_cls];
                head_next[tag_cls]  = unit_reg;
                empty_next[tag_cls] = 1'b0;
                ok_next             = 1'b1;
                echo_next           = 1'b0;
                res_cls_next        = tag_cls;
                state_next          = ST_DONE;
            end
            ST_DONE: begin
                // Load the output register once it is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_granted_next = ok_reg;
                    m_class_next   = res_cls_reg;
                    if (ok_reg) begin
                        m_offset_next = off_prod[15:0];
                    end else if (echo_reg) begin
                        m_offset_next = off_reg;
                    end else begin
                        m_offset_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            cur_reg      <= '0;
            lvl_reg      <= CLS_SMALL;
            req_cls_reg  <= CLS_SMALL;
            head_reg     <= '{default: '0};
            empty_reg    <= {(UNITS == 0), 1'b1, 1'b1};
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cur_reg      <= cur_next;
            lvl_reg      <= lvl_next;
            req_cls_reg  <= req_cls_next;
            head_reg     <= head_next;
            empty_reg    <= empty_next;
            m_valid_reg  <= m_valid_next;
        end
        off_reg       <= off_next;
        prod_reg      <= prod_next;
        unit_reg      <= unit_next;
        limit_reg     <= limit_next;
        ok_reg        <= ok_next;
        echo_reg      <= echo_next;
        res_cls_reg   <= res_cls_next;
        m_granted_reg <= m_granted_next;
        m_offset_reg  <= m_offset_next;
        m_class_reg   <= m_class_next;
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_granted       = m_granted_reg;
    assign m_result_offset = m_offset_reg;
    assign m_size_class    = m_class_reg;

endmodule

>>> hdl/sfa_checker.sv
// Port-level checks for the allocator
module sfa_checker import sfa_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_granted,
    input logic [15:0] m_result_offset,
    input logic [1:0]  m_size_class
);

    logic [1:0] outstanding_reg, outstanding_next;

    // Count items accepted but not yet delivered
    always_comb begin
        outstanding_next = outstanding_reg;
        if ((s_valid && s_ready) && !(m_valid && m_ready)) begin
            outstanding_next = outstanding_reg + 2'd1;
        end else if (!(s_valid && s_ready) && (m_valid && m_ready)) begin
            outstanding_next = outstanding_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            outstanding_reg <= '0;
        end else begin
            outstanding_reg <= outstanding_next;
        end
    end

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_granted)
            && $stable(m_result_offset) && $stable(m_size_class))
        else $error("result changed while stalled");

    // Go busy after taking an item
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready stayed high after an accepted item");

    // Never show a result without an accepted item behind it
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> outstanding_reg != 2'd0)
        else $error("result with no item outstanding");

    // At most one item at work plus one waiting in the output register
    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        outstanding_reg != 2'd3)
        else $error("too many items outstanding");

endmodule

bind segregated_freelist_allocator_unit sfa_checker u_sfa_checker (.*);
